// File: sv/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int ID_BITS = 16;
   localparam int PRIO_BITS = 8;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_POP    = 2'd2
   } shift_op_type;

   typedef struct packed {
      logic                 opcode;
      logic [ID_BITS-1:0]   proc_id;
      logic [PRIO_BITS-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ID_BITS-1:0]   out_id;
      logic [PRIO_BITS-1:0] out_priority;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      shift_op_type op;
      entry_type    entry;
   } cell_ctl_type;

endpackage

// File: sv/stable_priority_queue_core.sv
// latency: the response strobes in the cycle after the transaction is accepted
// throughput: one transaction per cycle while busy is low, the whole cell chain shifts together
// capacity is the number of cells in the chain; busy is high during reset and for the cycle after it
// reset clears the entry count, stored entries are not cleared
// the receiver cannot stall, every response is shown for exactly one cycle
module stable_priority_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);

   logic                            busy_ff;
   logic                            rsp_valid_ff;
   spq_pkg::rsp_type                rsp_ff;
   spq_pkg::rsp_type                rsp_in;
   logic [spq_pkg::COUNT_BITS-1:0]  count_ff;
   logic [spq_pkg::COUNT_BITS-1:0]  count_in;
   logic                            accept;
   logic                            full;
   logic                            empty;
   spq_pkg::cell_ctl_type           ctl;
   spq_pkg::entry_type              cell_entry [spq_pkg::DEPTH];
   logic [spq_pkg::DEPTH-1:0]       cell_place;
   logic [spq_pkg::DEPTH-1:0]       occupied;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == spq_pkg::COUNT_BITS'(spq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctl.entry.id   = req_data.proc_id;
      ctl.entry.prio = req_data.priority_req;
      ctl.op         = spq_pkg::SHIFT_HOLD;
      count_in       = count_ff;
      rsp_in         = '0;
      if (req_data.opcode == spq_pkg::OP_ENQUEUE) begin
         if (full) begin
            rsp_in.status = spq_pkg::ST_FULL;
         end else begin
            rsp_in.status = spq_pkg::ST_ENQUEUED;
            if (accept) begin
               ctl.op   = spq_pkg::SHIFT_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
      end else begin
         if (empty) begin
            rsp_in.status = spq_pkg::ST_EMPTY;
         end else begin
            rsp_in.status       = spq_pkg::ST_DEQUEUED;
            rsp_in.out_id       = cell_entry[0].id;
            rsp_in.out_priority = cell_entry[0].prio;
            if (accept) begin
               ctl.op   = spq_pkg::SHIFT_POP;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;
         logic               left_place;

         assign occupied[i] = (count_ff > spq_pkg::COUNT_BITS'(i));

         if (i == 0) begin : g_first
            assign left_place = 1'b1;
            assign left_entry = '0;
         end else begin : g_inner
            assign left_place = cell_place[i-1];
            assign left_entry = cell_entry[i-1];
         end

         if (i == spq_pkg::DEPTH - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_body
            assign right_entry = cell_entry[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .left_place  (left_place),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .place       (cell_place[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_rsp_per_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == $past(accept && !reset))
      else $error("response strobe does not follow an accepted transaction");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::COUNT_BITS'(spq_pkg::DEPTH))
      else $error("entry count beyond capacity");

   a_full_rejects: assert property (@(posedge clock) disable iff (reset)
      accept && full && req_data.opcode == spq_pkg::OP_ENQUEUE
      |=> rsp_data.status == spq_pkg::ST_FULL && $stable(count_ff))
      else $error("enqueue into a full queue not rejected");

   a_empty_reports: assert property (@(posedge clock) disable iff (reset)
      accept && empty && req_data.opcode == spq_pkg::OP_DEQUEUE
      |=> rsp_data.status == spq_pkg::ST_EMPTY && count_ff == '0)
      else $error("dequeue from an empty queue not reported");

endmodule

// File: sv/spq_cell.sv
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                 occupied,
   input  logic                 left_place,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry,
   output logic                 place
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // stays put when it holds an entry that outranks or ties the new one
   assign place = occupied && (entry_ff.prio >= ctl.entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         spq_pkg::SHIFT_POP: begin
            entry_in = right_entry;
         end
         spq_pkg::SHIFT_INSERT: begin
            if (place) begin
               entry_in = entry_ff;
            end else if (left_place) begin
               entry_in = ctl.entry;
            end else begin
               entry_in = left_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: tb/stable_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   spq_pkg::rsp_type rsp_data;

   spq_pkg::req_type   pending_req[$];
   spq_pkg::rsp_type   expected_rsp[$];
   spq_pkg::entry_type model_store[spq_pkg::DEPTH];
   int                 model_count;
   int                 sent_count;
   int                 stall_cycles;
   int                 errors;

   stable_priority_queue_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic spq_pkg::req_type make_req(spq_pkg::opcode_type op,
                                                 logic [spq_pkg::ID_BITS-1:0] id,
                                                 logic [spq_pkg::PRIO_BITS-1:0] prio);
      spq_pkg::req_type r;
      r.opcode       = op;
      r.proc_id      = id;
      r.priority_req = prio;
      return r;
   endfunction

   // sorted insert behind equal or higher priorities, pop from the front
   function automatic spq_pkg::rsp_type apply_queue_op(spq_pkg::req_type r);
      spq_pkg::rsp_type res;
      int               pos;
      res = '0;
      if (spq_pkg::opcode_type'(r.opcode) == spq_pkg::OP_ENQUEUE) begin
         if (model_count >= spq_pkg::DEPTH) begin
            res.status = spq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < model_count && model_store[pos].prio >= r.priority_req)
               pos++;
            for (int k = model_count; k > pos; k--)
               model_store[k] = model_store[k-1];
            model_store[pos].id   = r.proc_id;
            model_store[pos].prio = r.priority_req;
            model_count++;
            res.status = spq_pkg::ST_ENQUEUED;
         end
      end else begin
         if (model_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
         end else begin
            res.status       = spq_pkg::ST_DEQUEUED;
            res.out_id       = model_store[0].id;
            res.out_priority = model_store[0].prio;
            for (int k = 1; k < model_count; k++)
               model_store[k-1] = model_store[k];
            model_count--;
         end
      end
      return res;
   endfunction

   function automatic logic [spq_pkg::PRIO_BITS-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return spq_pkg::PRIO_BITS'($urandom_range(0, 3));
         1: return ($urandom_range(0, 1) == 1) ? '1 : '0;
         default: return spq_pkg::PRIO_BITS'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(apply_queue_op(req_data));
            void'(pending_req.pop_front());
            sent_count++;
         end
         go = pending_req.size() > 0;
         if (!(sent_count >= 500 && sent_count < 800) && $urandom_range(0, 99) < 30)
            go = 1'b0;
         start <= go;
         if (go)
            req_data <= pending_req[0];
      end
   end

   // monitor
   always @(posedge clock) begin
      spq_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected transaction: status %0d id %0h priority %0h",
                   rsp_data.status, rsp_data.out_id, rsp_data.out_priority);
            errors++;
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d", exp_rsp.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.out_id !== exp_rsp.out_id) begin
               $error("out_id: expected %0h actual %0h", exp_rsp.out_id, rsp_data.out_id);
               errors++;
            end
            if (rsp_data.out_priority !== exp_rsp.out_priority) begin
               $error("out_priority: expected %0h actual %0h",
                      exp_rsp.out_priority, rsp_data.out_priority);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("stable_priority_queue_core_tb NOT OK");
      $finish;
   end

   initial begin
      logic [spq_pkg::PRIO_BITS-1:0] fill_prio[16];
      logic [spq_pkg::ID_BITS-1:0]   fill_id[16];
      int                            phase_len;
      int                            enq_pct;
      int                            total;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      model_count  = 0;
      sent_count   = 0;
      stall_cycles = 0;
      errors       = 0;

      fill_prio = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h07, 8'h80,
                    8'hFF, 8'h01, 8'hFE, 8'h00, 8'h80, 8'h40, 8'h40, 8'hFF};
      fill_id   = '{16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000,
                    16'h7FFF, 16'h0002, 16'h1234, 16'hFFFE, 16'h0003, 16'h0004,
                    16'h0005, 16'h0006, 16'h0007, 16'h0008};

      // empty, fill to capacity with ties and extremes, full, partial drain
      pending_req.push_back(make_req(spq_pkg::OP_DEQUEUE, '1, '1));
      for (int i = 0; i < spq_pkg::DEPTH; i++)
         pending_req.push_back(make_req(spq_pkg::OP_ENQUEUE, fill_id[i], fill_prio[i]));
      pending_req.push_back(make_req(spq_pkg::OP_ENQUEUE, 16'hBEEF, 8'hFF));
      for (int i = 0; i < 5; i++)
         pending_req.push_back(make_req(spq_pkg::OP_DEQUEUE, 16'(i), 8'(i)));

      // phases that lean toward filling or draining the queue, or keep it balanced
      total = pending_req.size();
      while (total < 1400) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_pct = 15;
            1: enq_pct = 50;
            default: enq_pct = 85;
         endcase
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) < enq_pct)
               pending_req.push_back(make_req(spq_pkg::OP_ENQUEUE,
                                              spq_pkg::ID_BITS'($urandom),
                                              pick_priority()));
            else
               pending_req.push_back(make_req(spq_pkg::OP_DEQUEUE,
                                              spq_pkg::ID_BITS'($urandom),
                                              spq_pkg::PRIO_BITS'($urandom)));
         end
         total += phase_len;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending_req.size() == 0 && expected_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("stable_priority_queue_core_tb OK");
      end else begin
         $display("stable_priority_queue_core_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_core.sv
tb/stable_priority_queue_core_tb.sv
